// ===== design/pse_pkg.sv =====
`default_nettype none

package pse_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned DATA_WIDTH  = 32;
  localparam int unsigned SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CNT_W       = $clog2(DATA_WIDTH + 1);
  localparam int unsigned CMD_W       = 4;
  localparam int unsigned LIT_W       = 31;
  localparam int unsigned RES_W       = 32;
  localparam int unsigned ST_W        = 2;

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 4'd0,
    CMD_ADD  = 4'd1,
    CMD_SUB  = 4'd2,
    CMD_MUL  = 4'd3,
    CMD_DIV  = 4'd4,
    CMD_MOD  = 4'd5,
    CMD_POW  = 4'd6,
    CMD_GT   = 4'd7,
    CMD_GE   = 4'd8,
    CMD_LT   = 4'd9,
    CMD_LE   = 4'd10,
    CMD_EQ   = 4'd11,
    CMD_NE   = 4'd12,
    CMD_AND  = 4'd13,
    CMD_OR   = 4'd14
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_DIVZERO = 2'd1,
    ST_UNDER   = 2'd2,
    ST_OVER    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_UP,
    CELL_DN
  } cell_mode_e;

  typedef enum logic [1:0] {
    IT_DIV,
    IT_MOD,
    IT_POW
  } iter_kind_e;

  typedef struct packed {
    logic       start;
    iter_kind_e kind;
    word_t      lhs;
    word_t      rhs;
  } iter_req_t;

  typedef struct packed {
    logic  done;
    word_t value;
  } iter_rsp_t;

  // zero-extend or truncate a literal to the stack word
  function automatic word_t lit_to_word(input logic [LIT_W-1:0] lit);
    logic [DATA_WIDTH+LIT_W-1:0] ext;
    ext = {{DATA_WIDTH{1'b0}}, lit};
    return ext[DATA_WIDTH-1:0];
  endfunction

  // sign-extend or truncate a stack word to the result width
  function automatic logic [RES_W-1:0] word_to_res(input word_t w);
    logic [DATA_WIDTH+RES_W-1:0] ext;
    ext = {{RES_W{w[DATA_WIDTH-1]}}, w};
    return ext[RES_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/pse_if.sv =====
`default_nettype none

interface pse_in_if;
  import pse_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [LIT_W-1:0] operand_value;
  logic             is_last;

  modport source (output valid, output cmd, output operand_value, output is_last,
                  input ready);
  modport sink   (input valid, input cmd, input operand_value, input is_last,
                  output ready);
endinterface

interface pse_out_if;
  import pse_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] result_value;
  logic [ST_W-1:0]         status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink   (input valid, input result_value, input status, output ready);
endinterface

`default_nettype wire

// ===== design/pse_cell.sv =====
`default_nettype none

module pse_cell import pse_pkg::*; (
  input  wire logic       clk_i,
  input  wire cell_mode_e mode_i,
  input  wire word_t      up_i,
  input  wire word_t      dn_i,
  output word_t           val_o
);

  word_t val_q, val_d;

  always_comb begin
    case (mode_i)
      CELL_UP: val_d = up_i;
      CELL_DN: val_d = dn_i;
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

// ===== design/pse_iter.sv =====
`default_nettype none

// Shared multi-cycle unit: restoring division on magnitudes, or
// square-and-multiply power, one step per cycle.
module pse_iter import pse_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire iter_req_t req_i,
  output iter_rsp_t      rsp_o
);

  logic             busy_q, busy_d;
  iter_kind_e       kind_q, kind_d;
  word_t            a_q, a_d;   // quotient / accumulator
  word_t            b_q, b_d;   // remainder / base
  word_t            c_q, c_d;   // divisor magnitude / exponent
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             qneg_q, qneg_d;
  logic             lneg_q, lneg_d;

  word_t                 lmag, rmag;
  logic [DATA_WIDTH:0]   trial, diff;

  always_comb begin
    busy_d = busy_q;
    kind_d = kind_q;
    a_d    = a_q;
    b_d    = b_q;
    c_d    = c_q;
    cnt_d  = cnt_q;
    qneg_d = qneg_q;
    lneg_d = lneg_q;
    rsp_o  = '0;

    lmag  = req_i.lhs[DATA_WIDTH-1] ? word_t'('0 - req_i.lhs) : req_i.lhs;
    rmag  = req_i.rhs[DATA_WIDTH-1] ? word_t'('0 - req_i.rhs) : req_i.rhs;
    trial = {b_q, a_q[DATA_WIDTH-1]};
    diff  = trial - {1'b0, c_q};

    if (req_i.start) begin
      busy_d = 1'b1;
      kind_d = req_i.kind;
      cnt_d  = '0;
      qneg_d = req_i.lhs[DATA_WIDTH-1] ^ req_i.rhs[DATA_WIDTH-1];
      lneg_d = req_i.lhs[DATA_WIDTH-1];
      if (req_i.kind == IT_POW) begin
        a_d = word_t'(1);
        b_d = req_i.lhs;
        c_d = req_i.rhs;
      end else begin
        a_d = lmag;
        b_d = '0;
        c_d = rmag;
      end
    end else if (busy_q) begin
      case (kind_q)
        IT_POW: begin
          if (c_q == '0) begin
            rsp_o.done  = 1'b1;
            rsp_o.value = a_q;
            busy_d      = 1'b0;
          end else begin
            if (c_q[0]) begin
              a_d = a_q * b_q;
            end
            b_d = b_q * b_q;
            c_d = c_q >> 1;
          end
        end
        default: begin
          if (cnt_q == CNT_W'(DATA_WIDTH)) begin
            rsp_o.done = 1'b1;
            busy_d     = 1'b0;
            if (kind_q == IT_DIV) begin
              rsp_o.value = qneg_q ? word_t'('0 - a_q) : a_q;
            end else begin
              rsp_o.value = lneg_q ? word_t'('0 - b_q) : b_q;
            end
          end else begin
            if (!diff[DATA_WIDTH]) begin
              b_d = diff[DATA_WIDTH-1:0];
              a_d = {a_q[DATA_WIDTH-2:0], 1'b1};
            end else begin
              b_d = trial[DATA_WIDTH-1:0];
              a_d = {a_q[DATA_WIDTH-2:0], 1'b0};
            end
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      kind_q <= IT_DIV;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      kind_q <= kind_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    qneg_q <= qneg_d;
    lneg_q <= lneg_d;
  end

endmodule

`default_nettype wire

// ===== design/postfix_stack_evaluator_unit.sv =====
`default_nettype none

// Postfix evaluator: one token per transaction on in_i, one result transaction on
// out_o for each token marked last. The stack is a row of shift cells, top at cell
// 0. A push or a combinational operator (add, sub, mul, compares, logical and/or,
// power with a negative exponent) completes when the token is taken; div and mod,
// and power with a non-negative exponent, wait in a busy state for the shared
// iterative unit doing one quotient bit or one square-and-multiply step per cycle.
// A token marked last then goes to an emit state that outputs the top value and
// status once the output slot is free, after which the stack and the sticky error
// are cleared. A new token is taken only when the previous one is finished.
module postfix_stack_evaluator_unit import pse_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pse_in_if.sink     in_i,
  pse_out_if.source  out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_BUSY,
    S_EMIT
  } state_e;

  state_e           state_q, state_d;
  logic [SP_W-1:0]  sp_q, sp_d;
  status_e          err_q, err_d;
  logic             last_q, last_d;
  logic             out_valid_q, out_valid_d;
  logic [RES_W-1:0] out_res_q, out_res_d;
  status_e          out_st_q, out_st_d;

  cell_mode_e       mode_top, mode_rest;
  word_t            top_new;
  word_t            cell_val [STACK_DEPTH];
  iter_req_t        iter_req;
  iter_rsp_t        iter_rsp;

  word_t            lhs, rhs, alu_res;
  logic             accept;
  status_e          emit_st;

  assign lhs    = cell_val[1];
  assign rhs    = cell_val[0];
  assign accept = in_i.valid && in_i.ready;

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = out_res_q;
  assign out_o.status       = out_st_q;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    cell_mode_e c_mode;
    word_t      c_up, c_dn;
    if (i == 0) begin : g_top
      assign c_mode = mode_top;
      assign c_up   = top_new;
    end else begin : g_body
      assign c_mode = mode_rest;
      assign c_up   = cell_val[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign c_dn = '0;
    end else begin : g_mid
      assign c_dn = cell_val[i+1];
    end
    pse_cell u_cell (
      .clk_i  (clk_i),
      .mode_i (c_mode),
      .up_i   (c_up),
      .dn_i   (c_dn),
      .val_o  (cell_val[i])
    );
  end

  pse_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (iter_req),
    .rsp_o  (iter_rsp)
  );

  // combinational operators
  always_comb begin
    case (cmd_e'(in_i.cmd))
      CMD_ADD: alu_res = lhs + rhs;
      CMD_SUB: alu_res = lhs - rhs;
      CMD_MUL: alu_res = lhs * rhs;
      CMD_GT:  alu_res = {{(DATA_WIDTH-1){1'b0}}, $signed(lhs) >  $signed(rhs)};
      CMD_GE:  alu_res = {{(DATA_WIDTH-1){1'b0}}, $signed(lhs) >= $signed(rhs)};
      CMD_LT:  alu_res = {{(DATA_WIDTH-1){1'b0}}, $signed(lhs) <  $signed(rhs)};
      CMD_LE:  alu_res = {{(DATA_WIDTH-1){1'b0}}, $signed(lhs) <= $signed(rhs)};
      CMD_EQ:  alu_res = {{(DATA_WIDTH-1){1'b0}}, lhs == rhs};
      CMD_NE:  alu_res = {{(DATA_WIDTH-1){1'b0}}, lhs != rhs};
      CMD_AND: alu_res = {{(DATA_WIDTH-1){1'b0}}, (lhs != '0) && (rhs != '0)};
      CMD_OR:  alu_res = {{(DATA_WIDTH-1){1'b0}}, (lhs != '0) || (rhs != '0)};
      // power with a negative exponent truncates to 0 except for bases 1 and -1
      CMD_POW: begin
        if (lhs == word_t'(1)) begin
          alu_res = word_t'(1);
        end else if (lhs == '1) begin
          alu_res = rhs[0] ? '1 : word_t'(1);
        end else begin
          alu_res = '0;
        end
      end
      default: alu_res = '0;
    endcase
  end

  always_comb begin
    if (err_q != ST_OK) begin
      emit_st = err_q;
    end else if (sp_q == '0) begin
      emit_st = ST_UNDER;
    end else begin
      emit_st = ST_OK;
    end
  end

  always_comb begin
    state_d     = state_q;
    sp_d        = sp_q;
    err_d       = err_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_res_d   = out_res_q;
    out_st_d    = out_st_q;
    mode_top    = CELL_HOLD;
    mode_rest   = CELL_HOLD;
    top_new     = alu_res;
    iter_req    = '{start: 1'b0, kind: IT_DIV, lhs: lhs, rhs: rhs};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          last_d  = in_i.is_last;
          state_d = in_i.is_last ? S_EMIT : S_IDLE;
          if (err_q == ST_OK) begin
            case (cmd_e'(in_i.cmd))
              CMD_PUSH: begin
                if (sp_q == SP_W'(STACK_DEPTH)) begin
                  err_d = ST_OVER;
                end else begin
                  top_new   = lit_to_word(in_i.operand_value);
                  mode_top  = CELL_UP;
                  mode_rest = CELL_UP;
                  sp_d      = sp_q + SP_W'(1);
                end
              end
              CMD_ADD, CMD_SUB, CMD_MUL, CMD_GT, CMD_GE, CMD_LT, CMD_LE,
              CMD_EQ, CMD_NE, CMD_AND, CMD_OR, CMD_DIV, CMD_MOD, CMD_POW: begin
                if (sp_q < SP_W'(2)) begin
                  err_d = ST_UNDER;
                end else if ((cmd_e'(in_i.cmd) == CMD_DIV ||
                              cmd_e'(in_i.cmd) == CMD_MOD) && rhs == '0) begin
                  err_d = ST_DIVZERO;
                end else if (cmd_e'(in_i.cmd) == CMD_DIV ||
                             cmd_e'(in_i.cmd) == CMD_MOD ||
                             (cmd_e'(in_i.cmd) == CMD_POW && !rhs[DATA_WIDTH-1])) begin
                  iter_req.start = 1'b1;
                  case (cmd_e'(in_i.cmd))
                    CMD_DIV: iter_req.kind = IT_DIV;
                    CMD_MOD: iter_req.kind = IT_MOD;
                    default: iter_req.kind = IT_POW;
                  endcase
                  state_d = S_BUSY;
                end else if (cmd_e'(in_i.cmd) == CMD_POW && lhs == '0) begin
                  // zero to a negative power
                  err_d = ST_DIVZERO;
                end else begin
                  mode_top  = CELL_UP;
                  mode_rest = CELL_DN;
                  sp_d      = sp_q - SP_W'(1);
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_BUSY: begin
        if (iter_rsp.done) begin
          top_new   = iter_rsp.value;
          mode_top  = CELL_UP;
          mode_rest = CELL_DN;
          sp_d      = sp_q - SP_W'(1);
          state_d   = last_q ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_st_d    = emit_st;
          out_res_d   = (emit_st == ST_OK) ? word_to_res(cell_val[0]) : '0;
          sp_d        = '0;
          err_d       = ST_OK;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      err_q       <= ST_OK;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
      out_st_q    <= ST_OK;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      err_q       <= err_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      out_res_q   <= out_res_d;
      out_st_q    <= out_st_d;
    end
  end

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iter_rsp.done |-> state_q == S_BUSY)
    else $error("iterative result outside busy state");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && (!out_valid_q || out_o.ready))
      |=> out_valid_q && sp_q == '0 && err_q == ST_OK && state_q == S_IDLE)
    else $error("emit did not load result and clear stack");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_st_q != ST_OK) |-> out_res_q == '0)
    else $error("nonzero result with error status");

endmodule

`default_nettype wire

// ===== verif/tb_postfix_stack_evaluator_unit.sv =====
`default_nettype none

module tb_postfix_stack_evaluator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import pse_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED     = 4'd15;
  localparam logic [LIT_W-1:0] LIT_MAX        = '1;
  localparam int unsigned      TOKEN_TARGET   = 1800;
  localparam int unsigned      IDLE_PCT       = 7;
  localparam int unsigned      QUIET_FROM     = 700;
  localparam int unsigned      QUIET_TO       = 1000;
  localparam int unsigned      DRAIN_CYCLES   = 40;
  localparam int unsigned      WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [LIT_W-1:0] lit;
    logic             is_last;
  } token_t;

  typedef struct packed {
    logic signed [RES_W-1:0] value;
    status_e                 status;
  } outcome_t;

  logic clk_i;
  logic rst_ni;

  pse_in_if  in_if ();
  pse_out_if out_if ();

  postfix_stack_evaluator_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  token_t      pending_tokens[$];
  outcome_t    expected_outcomes[$];
  token_t      next_tok;
  outcome_t    want;

  // shadow of the evaluator state
  word_t       stack_model[STACK_DEPTH];
  int unsigned depth_model;
  status_e     error_model;

  int unsigned err_cnt;
  int unsigned gen_count;
  int unsigned tokens_accepted;
  int unsigned results_seen;
  int unsigned max_depth_seen;
  int unsigned idle_cycles;
  int unsigned status_seen[4];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // expected outcome of one accepted token, applied to the shadow stack
  task automatic evaluate_token(input logic [CMD_W-1:0] cmd, input logic [LIT_W-1:0] lit,
                                input logic is_last);
    word_t    rhs, lhs, res, mag_l, mag_r, base, expo;
    logic     fault;
    status_e  st;
    outcome_t o;
    res   = '0;
    fault = 1'b0;
    if (error_model == ST_OK) begin
      if (cmd == CMD_PUSH) begin
        if (depth_model >= STACK_DEPTH) begin
          error_model = ST_OVER;
        end else begin
          stack_model[depth_model] = word_t'(lit);
          depth_model++;
          if (depth_model > max_depth_seen) max_depth_seen = depth_model;
        end
      end else if (cmd != CMD_UNUSED) begin
        if (depth_model < 2) begin
          error_model = ST_UNDER;
        end else begin
          rhs   = stack_model[depth_model-1];
          lhs   = stack_model[depth_model-2];
          mag_l = lhs[DATA_WIDTH-1] ? -lhs : lhs;
          mag_r = rhs[DATA_WIDTH-1] ? -rhs : rhs;
          case (cmd)
            CMD_ADD: res = lhs + rhs;
            CMD_SUB: res = lhs - rhs;
            CMD_MUL: res = lhs * rhs;
            CMD_DIV: begin
              if (rhs == '0) begin
                fault = 1'b1;
              end else begin
                res = mag_l / mag_r;
                if (lhs[DATA_WIDTH-1] ^ rhs[DATA_WIDTH-1]) res = -res;
              end
            end
            CMD_MOD: begin
              if (rhs == '0) begin
                fault = 1'b1;
              end else begin
                res = mag_l % mag_r;
                if (lhs[DATA_WIDTH-1]) res = -res;
              end
            end
            CMD_POW: begin
              if (rhs[DATA_WIDTH-1]) begin
                // negative exponent: truncated power
                if (lhs == word_t'(1)) res = word_t'(1);
                else if (lhs == '1) res = rhs[0] ? '1 : word_t'(1);
                else if (lhs == '0) fault = 1'b1;
                else res = '0;
              end else begin
                res  = word_t'(1);
                base = lhs;
                expo = rhs;
                while (expo != '0) begin
                  if (expo[0]) res = res * base;
                  base = base * base;
                  expo = expo >> 1;
                end
              end
            end
            CMD_GT:  res = word_t'($signed(lhs) >  $signed(rhs));
            CMD_GE:  res = word_t'($signed(lhs) >= $signed(rhs));
            CMD_LT:  res = word_t'($signed(lhs) <  $signed(rhs));
            CMD_LE:  res = word_t'($signed(lhs) <= $signed(rhs));
            CMD_EQ:  res = word_t'(lhs == rhs);
            CMD_NE:  res = word_t'(lhs != rhs);
            CMD_AND: res = word_t'((lhs != '0) && (rhs != '0));
            default: res = word_t'((lhs != '0) || (rhs != '0));
          endcase
          if (fault) begin
            error_model = ST_DIVZERO;
          end else begin
            depth_model--;
            stack_model[depth_model-1] = res;
          end
        end
      end
    end
    if (is_last) begin
      st = error_model;
      if (st == ST_OK && depth_model == 0) st = ST_UNDER;
      o.status = st;
      if (st == ST_OK) o.value = $signed(stack_model[depth_model-1]);
      else o.value = '0;
      expected_outcomes.push_back(o);
      depth_model = 0;
      error_model = ST_OK;
    end
  endtask

  function automatic logic take_break();
    if (tokens_accepted >= QUIET_FROM && tokens_accepted < QUIET_TO) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  function automatic logic [LIT_W-1:0] rand_literal();
    case ($urandom_range(9))
      0, 1, 2: return LIT_W'($urandom_range(4));
      3:       return LIT_MAX;
      4:       return LIT_MAX - LIT_W'($urandom_range(3));
      5:       return LIT_W'($urandom_range(40));
      default: return LIT_W'($urandom);
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] rand_operator();
    return CMD_W'($urandom_range(int'(CMD_OR), int'(CMD_ADD)));
  endfunction

  task automatic add_token(input logic [CMD_W-1:0] cmd, input logic [LIT_W-1:0] lit);
    token_t t;
    t.cmd     = cmd;
    t.lit     = lit;
    t.is_last = 1'b0;
    pending_tokens.push_back(t);
    if (cmd != CMD_UNUSED) gen_count++;
  endtask

  task automatic close_expression();
    pending_tokens[pending_tokens.size()-1].is_last = 1'b1;
  endtask

  // one operand: a literal, or a small negative / most negative value built by subtraction
  task automatic gen_operand(inout int unsigned depth);
    case ($urandom_range(19))
      0, 1, 2: begin
        if (depth + 2 <= STACK_DEPTH) begin
          add_token(CMD_PUSH, '0);
          add_token(CMD_PUSH, LIT_W'($urandom_range(3, 1)));
          add_token(CMD_SUB, LIT_W'($urandom));
        end else begin
          add_token(CMD_PUSH, rand_literal());
        end
      end
      3: begin
        if (depth + 2 <= STACK_DEPTH) begin
          add_token(CMD_PUSH, '0);
          add_token(CMD_PUSH, LIT_MAX);
          add_token(CMD_SUB, LIT_W'($urandom));
          add_token(CMD_PUSH, LIT_W'(1));
          add_token(CMD_SUB, LIT_W'($urandom));
        end else begin
          add_token(CMD_PUSH, rand_literal());
        end
      end
      default: add_token(CMD_PUSH, rand_literal());
    endcase
    depth++;
  endtask

  task automatic gen_well_formed(input int unsigned n_operands);
    int unsigned depth;
    int unsigned left;
    depth = 0;
    left  = n_operands;
    while (left > 0 || depth > 1) begin
      if (left > 0 && (depth < 2 || $urandom_range(1) == 0) && depth < STACK_DEPTH) begin
        gen_operand(depth);
        left--;
      end else begin
        add_token(rand_operator(), LIT_W'($urandom));
        depth--;
      end
      if ($urandom_range(39) == 0) add_token(CMD_UNUSED, LIT_W'($urandom));
    end
    close_expression();
  endtask

  // token driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid         <= 1'b0;
      in_if.cmd           <= '0;
      in_if.operand_value <= '0;
      in_if.is_last       <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        evaluate_token(in_if.cmd, in_if.operand_value, in_if.is_last);
        tokens_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_tokens.size() != 0 && !take_break()) begin
          next_tok            = pending_tokens.pop_front();
          in_if.valid         <= 1'b1;
          in_if.cmd           <= next_tok.cmd;
          in_if.operand_value <= next_tok.lit;
          in_if.is_last       <= next_tok.is_last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        status_seen[out_if.status]++;
        if (expected_outcomes.size() == 0) begin
          report_mismatch($sformatf("unexpected result: value %0d status %0d",
                                    out_if.result_value, out_if.status));
        end else begin
          want = expected_outcomes.pop_front();
          if (out_if.result_value !== want.value)
            report_mismatch($sformatf("result %0d: value %0d, want %0d", results_seen,
                                      out_if.result_value, want.value));
          if (out_if.status !== want.status)
            report_mismatch($sformatf("result %0d: status %0d, want %0d", results_seen,
                                      out_if.status, want.status));
        end
      end
      out_if.ready <= !take_break();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TIMEOUT @%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned pick;
    in_if.valid         = 1'b0;
    in_if.cmd           = '0;
    in_if.operand_value = '0;
    in_if.is_last       = 1'b0;
    out_if.ready        = 1'b0;
    rst_ni              = 1'b0;
    depth_model         = 0;
    error_model         = ST_OK;
    err_cnt             = 0;
    gen_count           = 0;
    tokens_accepted     = 0;
    results_seen        = 0;
    max_depth_seen      = 0;
    idle_cycles         = 0;
    status_seen         = '{default: 0};

    // one chain through every operator, starting from the most negative value
    add_token(CMD_PUSH, '0);
    add_token(CMD_PUSH, LIT_MAX);
    add_token(CMD_SUB, LIT_MAX);
    add_token(CMD_PUSH, LIT_W'(1));
    add_token(CMD_SUB, '0);
    add_token(CMD_PUSH, '0);
    add_token(CMD_PUSH, LIT_W'(1));
    add_token(CMD_SUB, '0);
    add_token(CMD_DIV, LIT_MAX);       // most negative / -1 wraps
    add_token(CMD_PUSH, LIT_MAX);
    add_token(CMD_ADD, '0);
    add_token(CMD_PUSH, LIT_W'(3));
    add_token(CMD_MUL, '0);
    add_token(CMD_PUSH, LIT_W'(2));
    add_token(CMD_MOD, '0);
    add_token(CMD_PUSH, '0);
    add_token(CMD_PUSH, LIT_W'(3));
    add_token(CMD_SUB, '0);
    add_token(CMD_POW, '0);            // base -1, negative odd exponent
    add_token(CMD_PUSH, '0);
    add_token(CMD_POW, '0);            // zero exponent
    add_token(CMD_PUSH, '0);
    add_token(CMD_GT, '0);
    add_token(CMD_PUSH, LIT_W'(1));
    add_token(CMD_GE, '0);
    add_token(CMD_PUSH, LIT_W'(2));
    add_token(CMD_LT, '0);
    add_token(CMD_PUSH, '0);
    add_token(CMD_LE, '0);
    add_token(CMD_PUSH, '0);
    add_token(CMD_EQ, '0);
    add_token(CMD_PUSH, LIT_W'(1));
    add_token(CMD_NE, '0);
    add_token(CMD_PUSH, LIT_W'(1));
    add_token(CMD_AND, '0);
    add_token(CMD_PUSH, LIT_W'(1));
    add_token(CMD_OR, LIT_MAX);
    close_expression();
    // last mark on an empty stack
    add_token(CMD_UNUSED, LIT_MAX);
    close_expression();
    // zero divisor
    add_token(CMD_PUSH, LIT_W'(5));
    add_token(CMD_PUSH, '0);
    add_token(CMD_DIV, '0);
    close_expression();

    while (gen_count < TOKEN_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 72) begin
        if ($urandom_range(7) == 0) gen_well_formed($urandom_range(12, 6));
        else gen_well_formed($urandom_range(5, 1));
      end else if (pick < 76) begin
        // fill the stack to the brim, then fold it down
        repeat (STACK_DEPTH) add_token(CMD_PUSH, rand_literal());
        repeat (STACK_DEPTH - 1) add_token(rand_operator(), LIT_W'($urandom));
        close_expression();
      end else if (pick < 80) begin
        repeat (STACK_DEPTH + 1) add_token(CMD_PUSH, rand_literal());
        repeat ($urandom_range(2)) add_token(rand_operator(), LIT_W'($urandom));
        close_expression();
      end else begin
        // noise: any code, stray last marks
        repeat ($urandom_range(6, 1)) begin
          add_token(CMD_W'($urandom_range(15)), LIT_W'($urandom));
          if ($urandom_range(3) == 0) close_expression();
        end
        close_expression();
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_tokens.size() != 0 || in_if.valid || expected_outcomes.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_outcomes.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_outcomes.size()));

    $display("Covered %0d tokens and %0d expressions, stack depth reaching %0d of %0d",
             tokens_accepted, results_seen, max_depth_seen, STACK_DEPTH);
    $display("Status mix: %0d ok, %0d divide by zero, %0d underflow, %0d overflow",
             status_seen[ST_OK], status_seen[ST_DIVZERO], status_seen[ST_UNDER],
             status_seen[ST_OVER]);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== postfix_stack_evaluator_unit.f =====
design/pse_pkg.sv
design/pse_if.sv
design/pse_cell.sv
design/pse_iter.sv
design/postfix_stack_evaluator_unit.sv
verif/tb_postfix_stack_evaluator_unit.sv
